@@ hw/rtl/pcord_pkg.sv @@
// Shared types, sizes and the control-word program of the permutation order core.
// Used by permutation_cycle_order_core and its testbench; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcord_pkg;

   localparam int ELEMENT_COUNT = 1024;
   localparam int ORDER_WIDTH   = 32;
   localparam int ELEM_W        = $clog2(ELEMENT_COUNT);
   localparam int OPEN_W        = 11;
   localparam int CLOSED_W      = 10;
   localparam int ROW_BITS      = 32;
   localparam int ROW_COUNT     = ELEMENT_COUNT / ROW_BITS;
   localparam int ROW_W         = $clog2(ROW_COUNT);
   localparam int BIT_W         = $clog2(ROW_BITS);
   localparam int CNT_W         = $clog2(ORDER_WIDTH);
   localparam int SHIFT_W       = $clog2(OPEN_W);
   localparam int PROD_W        = ORDER_WIDTH + OPEN_W;
   localparam int PC_W          = 4;

   localparam logic [OPEN_W-1:0]   OPEN_MAX   = {OPEN_W{1'b1}};
   localparam logic [CLOSED_W-1:0] CLOSED_MAX = {CLOSED_W{1'b1}};
   localparam logic [CNT_W-1:0]    CNT_LAST   = CNT_W'(ORDER_WIDTH - 1);
   localparam logic [ROW_W-1:0]    ROW_LAST   = ROW_W'(ROW_COUNT - 1);

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_CLOSE = 2'd1,
      REQ_QUERY = 2'd2
   } req_code_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_ADD_WRITE,
      OP_QUERY,
      OP_DIV_ORDER_LEN,
      OP_DIV_STEP,
      OP_GCD_LOAD,
      OP_GCD_STEP,
      OP_DIV_ORDER_G,
      OP_MUL,
      OP_ORDER_UPDATE,
      OP_CLOSE_END
   } op_type;

   typedef enum logic [1:0] {
      COND_NONE,
      COND_SKIP_FOLD,
      COND_DIV_MORE,
      COND_GCD_MORE
   } cond_type;

   typedef struct packed {
      op_type              op;
      cond_type            cond;
      logic [PC_W-1:0]     target;
      logic                last;
   } ucode_word_type;

   localparam logic [PC_W-1:0] STEP_ADD       = 4'd0;
   localparam logic [PC_W-1:0] STEP_ADD_WR    = 4'd1;
   localparam logic [PC_W-1:0] STEP_QUERY     = 4'd2;
   localparam logic [PC_W-1:0] STEP_QUERY_RD  = 4'd3;
   localparam logic [PC_W-1:0] STEP_CLOSE     = 4'd4;
   localparam logic [PC_W-1:0] STEP_DIV_LEN   = 4'd5;
   localparam logic [PC_W-1:0] STEP_GCD_LOAD  = 4'd6;
   localparam logic [PC_W-1:0] STEP_GCD       = 4'd7;
   localparam logic [PC_W-1:0] STEP_DIV_G_LD  = 4'd8;
   localparam logic [PC_W-1:0] STEP_DIV_G     = 4'd9;
   localparam logic [PC_W-1:0] STEP_MUL       = 4'd10;
   localparam logic [PC_W-1:0] STEP_UPDATE    = 4'd11;
   localparam logic [PC_W-1:0] STEP_CLOSE_END = 4'd12;
   localparam logic [PC_W-1:0] STEP_NOP       = 4'd13;

   // Entry step of the program for each request code.
   function automatic logic [PC_W-1:0] entry_step(input logic [1:0] code);
      logic [PC_W-1:0] step;
      case (code)
         REQ_ADD:   step = STEP_ADD;
         REQ_CLOSE: step = STEP_CLOSE;
         REQ_QUERY: step = STEP_QUERY;
         default:   step = STEP_NOP;
      endcase
      return step;
   endfunction

   // Control program. A taken condition jumps to target, otherwise the step
   // counter advances; a word marked last ends the request.
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] step);
      ucode_word_type w;
      case (step)
         STEP_ADD:       w = '{op: OP_NONE,          cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_ADD_WR:    w = '{op: OP_ADD_WRITE,     cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b1};
         STEP_QUERY:     w = '{op: OP_NONE,          cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_QUERY_RD:  w = '{op: OP_QUERY,         cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b1};
         STEP_CLOSE:     w = '{op: OP_DIV_ORDER_LEN, cond: COND_SKIP_FOLD,
                               target: STEP_CLOSE_END, last: 1'b0};
         STEP_DIV_LEN:   w = '{op: OP_DIV_STEP,      cond: COND_DIV_MORE,
                               target: STEP_DIV_LEN,   last: 1'b0};
         STEP_GCD_LOAD:  w = '{op: OP_GCD_LOAD,      cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_GCD:       w = '{op: OP_GCD_STEP,      cond: COND_GCD_MORE,
                               target: STEP_GCD,       last: 1'b0};
         STEP_DIV_G_LD:  w = '{op: OP_DIV_ORDER_G,   cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_DIV_G:     w = '{op: OP_DIV_STEP,      cond: COND_DIV_MORE,
                               target: STEP_DIV_G,     last: 1'b0};
         STEP_MUL:       w = '{op: OP_MUL,           cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_UPDATE:    w = '{op: OP_ORDER_UPDATE,  cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b0};
         STEP_CLOSE_END: w = '{op: OP_CLOSE_END,     cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b1};
         default:        w = '{op: OP_NONE,          cond: COND_NONE,
                               target: STEP_NOP,       last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/permutation_cycle_order_core.sv @@
// Permutation order core: a control-word sequencer over a divider, a gcd unit,
// a multiplier and a membership bitmap memory. Depends on pcord_pkg.
`timescale 1ns / 1ps
`default_nettype none

// How to use this block.
// A request (req_type, req_element) is taken at a rising edge where start is
// high and busy is low. Every request gives one result: rsp_valid is high for
// exactly one cycle and the rsp_ ports then show the state after the request.
// The receiver cannot stall; the result is taken at the edge that ends it.
// A new request may be started in the cycle that shows the previous result.
// Add and query run a setup step and then a write or read step; an unknown
// request code runs only the closing no-op step. A close of an empty or
// one-element cycle (or after the order has saturated) skips the fold; a close
// that folds a length into the order runs the shared divider twice, which
// retires one quotient bit per cycle, with the binary gcd loop on 11-bit
// operands between the two divisions, then a multiply and the order update.
// After reset the bitmap memory is cleared one 32-bit row per cycle; busy
// stays high until the last row is cleared. The order restarts at one and the
// cycle total and open length at zero.
module permutation_cycle_order_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_type,
   input  wire logic [pcord_pkg::ELEM_W-1:0]        req_element,
   output logic                                     rsp_valid,
   output logic [pcord_pkg::ORDER_WIDTH-1:0]        rsp_perm_order,
   output logic                                     rsp_order_overflow,
   output logic                                     rsp_is_member,
   output logic [pcord_pkg::CLOSED_W-1:0]           rsp_cycle_total,
   output logic [pcord_pkg::OPEN_W-1:0]             rsp_open_length
);

   localparam int ORDER_WIDTH = pcord_pkg::ORDER_WIDTH;
   localparam int OPEN_W      = pcord_pkg::OPEN_W;
   localparam int CLOSED_W    = pcord_pkg::CLOSED_W;
   localparam int ELEM_W      = pcord_pkg::ELEM_W;
   localparam int ROW_BITS    = pcord_pkg::ROW_BITS;
   localparam int ROW_W       = pcord_pkg::ROW_W;
   localparam int BIT_W       = pcord_pkg::BIT_W;
   localparam int CNT_W       = pcord_pkg::CNT_W;
   localparam int SHIFT_W     = pcord_pkg::SHIFT_W;
   localparam int PROD_W      = pcord_pkg::PROD_W;
   localparam int PC_W        = pcord_pkg::PC_W;

   // Control state.
   logic                    running_ff, running_in;
   logic                    strobe_ff, strobe_in;
   logic                    clearing_ff, clearing_in;
   logic [ROW_W-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [PC_W-1:0]         pc_ff, pc_in;
   logic [ORDER_WIDTH-1:0]  order_ff, order_in;
   logic                    ovf_ff, ovf_in;
   logic [CLOSED_W-1:0]     closed_ff, closed_in;
   logic [OPEN_W-1:0]       open_ff, open_in;
   logic                    member_ff, member_in;

   // Datapath registers.
   logic [ELEM_W-1:0]       elem_ff, elem_in;
   logic [OPEN_W-1:0]       rem_ff, rem_in;
   logic [ORDER_WIDTH-1:0]  quo_ff, quo_in;
   logic [OPEN_W-1:0]       den_ff, den_in;
   logic [CNT_W-1:0]        div_cnt_ff, div_cnt_in;
   logic [OPEN_W-1:0]       a_ff, a_in;
   logic [OPEN_W-1:0]       b_ff, b_in;
   logic [SHIFT_W-1:0]      k_ff, k_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [ROW_BITS-1:0]     rd_ff;

   logic [ROW_BITS-1:0]     map_mem [pcord_pkg::ROW_COUNT];

   pcord_pkg::ucode_word_type word;
   logic                    accept;
   logic                    take;
   logic [ROW_W-1:0]        elem_row;
   logic [BIT_W-1:0]        elem_bit;
   logic [ROW_BITS-1:0]     bit_mask;
   logic                    mem_we;
   logic [ROW_W-1:0]        mem_waddr;
   logic [ROW_BITS-1:0]     mem_wdata;
   logic [OPEN_W:0]         div_trial;
   logic [OPEN_W:0]         div_diff;
   logic                    div_fits;
   logic [OPEN_W-1:0]       gcd_value;

   assign busy     = running_ff | clearing_ff;
   assign accept   = start && !busy;
   assign word     = pcord_pkg::ucode_rom(pc_ff);
   assign elem_row = elem_ff[ELEM_W-1 -: ROW_W];
   assign elem_bit = elem_ff[BIT_W-1:0];
   assign bit_mask = {{(ROW_BITS-1){1'b0}}, 1'b1} << elem_bit;

   // One restoring division step: shift in the next dividend bit, subtract if it fits.
   assign div_trial = {rem_ff, quo_ff[ORDER_WIDTH-1]};
   assign div_diff  = div_trial - {1'b0, den_ff};
   assign div_fits  = div_trial >= {1'b0, den_ff};
   assign gcd_value = a_ff << k_ff;

   always_comb begin
      case (word.cond)
         pcord_pkg::COND_SKIP_FOLD: take = (open_ff < OPEN_W'(2)) || ovf_ff;
         pcord_pkg::COND_DIV_MORE:  take = div_cnt_ff != pcord_pkg::CNT_LAST;
         pcord_pkg::COND_GCD_MORE:  take = b_ff != '0;
         default:                   take = 1'b0;
      endcase
   end

   always_comb begin
      running_in  = running_ff;
      strobe_in   = 1'b0;
      clearing_in = clearing_ff;
      clr_cnt_in  = clr_cnt_ff;
      pc_in       = pc_ff;
      order_in    = order_ff;
      ovf_in      = ovf_ff;
      closed_in   = closed_ff;
      open_in     = open_ff;
      member_in   = member_ff;
      elem_in     = elem_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      den_in      = den_ff;
      div_cnt_in  = div_cnt_ff;
      a_in        = a_ff;
      b_in        = b_ff;
      k_in        = k_ff;
      prod_in     = prod_ff;
      mem_we      = 1'b0;
      mem_waddr   = elem_row;
      mem_wdata   = rd_ff | bit_mask;

      if (clearing_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_cnt_ff;
         mem_wdata  = '0;
         clr_cnt_in = clr_cnt_ff + ROW_W'(1);
         if (clr_cnt_ff == pcord_pkg::ROW_LAST) begin
            clearing_in = 1'b0;
         end
      end

      if (accept) begin
         running_in = 1'b1;
         elem_in    = req_element;
         pc_in      = pcord_pkg::entry_step(req_type);
      end

      if (running_ff) begin
         case (word.op)
            pcord_pkg::OP_ADD_WRITE: begin
               mem_we = 1'b1;
               if (open_ff != pcord_pkg::OPEN_MAX) begin
                  open_in = open_ff + OPEN_W'(1);
               end
            end
            pcord_pkg::OP_DIV_ORDER_LEN: begin
               rem_in     = '0;
               quo_in     = order_ff;
               den_in     = open_ff;
               div_cnt_in = '0;
            end
            pcord_pkg::OP_DIV_STEP: begin
               rem_in     = div_fits ? div_diff[OPEN_W-1:0] : div_trial[OPEN_W-1:0];
               quo_in     = {quo_ff[ORDER_WIDTH-2:0], div_fits};
               div_cnt_in = div_cnt_ff + CNT_W'(1);
            end
            pcord_pkg::OP_GCD_LOAD: begin
               // gcd(order, len) equals gcd(len, order mod len).
               a_in = open_ff;
               b_in = rem_ff;
               k_in = '0;
            end
            pcord_pkg::OP_GCD_STEP: begin
               if (b_ff != '0) begin
                  if (!a_ff[0] && !b_ff[0]) begin
                     a_in = a_ff >> 1;
                     b_in = b_ff >> 1;
                     k_in = k_ff + SHIFT_W'(1);
                  end else if (!a_ff[0]) begin
                     a_in = a_ff >> 1;
                  end else if (!b_ff[0]) begin
                     b_in = b_ff >> 1;
                  end else if (a_ff > b_ff) begin
                     a_in = (a_ff - b_ff) >> 1;
                  end else begin
                     b_in = (b_ff - a_ff) >> 1;
                  end
               end
            end
            pcord_pkg::OP_DIV_ORDER_G: begin
               rem_in     = '0;
               quo_in     = order_ff;
               den_in     = gcd_value;
               div_cnt_in = '0;
            end
            pcord_pkg::OP_MUL: begin
               prod_in = {{OPEN_W{1'b0}}, quo_ff} * {{ORDER_WIDTH{1'b0}}, open_ff};
            end
            pcord_pkg::OP_ORDER_UPDATE: begin
               if (prod_ff[PROD_W-1:ORDER_WIDTH] != '0) begin
                  order_in = {ORDER_WIDTH{1'b1}};
                  ovf_in   = 1'b1;
               end else begin
                  order_in = prod_ff[ORDER_WIDTH-1:0];
               end
            end
            pcord_pkg::OP_CLOSE_END: begin
               if (open_ff >= OPEN_W'(2) && closed_ff != pcord_pkg::CLOSED_MAX) begin
                  closed_in = closed_ff + CLOSED_W'(1);
               end
               open_in = '0;
            end
            default: begin
            end
         endcase

         if (word.last) begin
            running_in = 1'b0;
            strobe_in  = 1'b1;
            member_in  = (word.op == pcord_pkg::OP_QUERY) ? rd_ff[elem_bit] : 1'b0;
         end else if (take) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff  <= 1'b0;
         strobe_ff   <= 1'b0;
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
         pc_ff       <= pcord_pkg::STEP_NOP;
         order_ff    <= ORDER_WIDTH'(1);
         ovf_ff      <= 1'b0;
         closed_ff   <= '0;
         open_ff     <= '0;
         member_ff   <= 1'b0;
      end else begin
         running_ff  <= running_in;
         strobe_ff   <= strobe_in;
         clearing_ff <= clearing_in;
         clr_cnt_ff  <= clr_cnt_in;
         pc_ff       <= pc_in;
         order_ff    <= order_in;
         ovf_ff      <= ovf_in;
         closed_ff   <= closed_in;
         open_ff     <= open_in;
         member_ff   <= member_in;
      end
   end

   always_ff @(posedge clock) begin
      elem_ff    <= elem_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      den_ff     <= den_in;
      div_cnt_ff <= div_cnt_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      k_ff       <= k_in;
      prod_ff    <= prod_in;
   end

   // Bitmap memory: one write port, one registered read of the request's row.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         map_mem[mem_waddr] <= mem_wdata;
      end
      rd_ff <= map_mem[elem_row];
   end

   assign rsp_valid          = strobe_ff;
   assign rsp_perm_order     = order_ff;
   assign rsp_order_overflow = ovf_ff;
   assign rsp_is_member      = member_ff;
   assign rsp_cycle_total    = closed_ff;
   assign rsp_open_length    = open_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after an accepted request");

   a_no_result_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp_valid)
      else $error("result strobe one cycle after an accepted request");

   a_order_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_perm_order != '0)
      else $error("reported order is zero");

   a_overflow_saturates: assert property (@(posedge clock) disable iff (reset)
      rsp_order_overflow |-> &rsp_perm_order)
      else $error("overflow flag set without a saturated order");

endmodule

`default_nettype wire

@@ dv/permutation_cycle_order_core_test.sv @@
// Self-checking testbench for permutation_cycle_order_core: drives add, close and query
// requests (also unknown codes) and checks every result against a behavioral order
// tracker kept here. Depends on pcord_pkg and the core RTL only.
`timescale 1ns / 1ps

module permutation_cycle_order_core_test;

   localparam int ELEMENT_COUNT = pcord_pkg::ELEMENT_COUNT;
   localparam int ORDER_WIDTH   = pcord_pkg::ORDER_WIDTH;
   localparam int ELEM_W        = pcord_pkg::ELEM_W;
   localparam int OPEN_W        = pcord_pkg::OPEN_W;
   localparam int CLOSED_W      = pcord_pkg::CLOSED_W;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;
   localparam int RANDOM_REQUESTS = 850;
   localparam int WIDE_LENGTHS_FROM = 600;
   localparam int IDLE_LIMIT = 4000;
   localparam int REPORT_LIMIT = 10;

   typedef struct {
      logic [ORDER_WIDTH-1:0] perm_order;
      logic                   order_overflow;
      logic                   is_member;
      logic [CLOSED_W-1:0]    cycle_total;
      logic [OPEN_W-1:0]      open_length;
   } order_report_type;

   class cycle_order_checker;
      bit                   member_map [ELEMENT_COUNT];
      logic [63:0]          order_value;
      bit                   saturated;
      logic [CLOSED_W-1:0]  closed_cycles;
      logic [OPEN_W-1:0]    open_count;
      order_report_type     expected_reports [$];
      int                   failures;

      function new();
         foreach (member_map[i]) member_map[i] = 1'b0;
         order_value = 64'd1;
         saturated = 1'b0;
         closed_cycles = '0;
         open_count = '0;
         failures = 0;
      endfunction

      function logic [63:0] common_divisor(logic [63:0] a, logic [63:0] b);
         logic [63:0] t;
         while (b != 64'd0) begin
            t = a % b;
            a = b;
            b = t;
         end
         return a;
      endfunction

      // Folds a closed cycle length into the running lcm, saturating at the width.
      function void fold_length(logic [63:0] len);
         logic [63:0] limit;
         logic [63:0] part;
         limit = (64'd1 << ORDER_WIDTH) - 64'd1;
         if (saturated) return;
         part = order_value / common_divisor(order_value, len);
         if (part > limit / len) begin
            order_value = limit;
            saturated = 1'b1;
         end else begin
            order_value = part * len;
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [ELEM_W-1:0] elem);
         order_report_type want;
         want.is_member = 1'b0;
         case (kind)
            pcord_pkg::REQ_ADD: begin
               member_map[elem] = 1'b1;
               if (open_count != pcord_pkg::OPEN_MAX) open_count++;
            end
            pcord_pkg::REQ_CLOSE: begin
               if (open_count >= 2) begin
                  fold_length(64'(open_count));
                  if (closed_cycles != pcord_pkg::CLOSED_MAX) closed_cycles++;
               end
               open_count = '0;
            end
            pcord_pkg::REQ_QUERY: want.is_member = member_map[elem];
            default: ;
         endcase
         want.perm_order = order_value[ORDER_WIDTH-1:0];
         want.order_overflow = saturated;
         want.cycle_total = closed_cycles;
         want.open_length = open_count;
         expected_reports = {expected_reports, want};
      endfunction

      function void log_failure(string what, longint unsigned want, longint unsigned got);
         failures++;
         if (failures <= REPORT_LIMIT)
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
      endfunction

      function void check_report(order_report_type got);
         order_report_type want;
         if (expected_reports.size() == 0) begin
            log_failure("result with no request outstanding", 0, 0);
            return;
         end
         want = expected_reports.pop_front();
         if (got.perm_order !== want.perm_order)
            log_failure("perm_order", want.perm_order, got.perm_order);
         if (got.order_overflow !== want.order_overflow)
            log_failure("order_overflow", want.order_overflow, got.order_overflow);
         if (got.is_member !== want.is_member)
            log_failure("is_member", want.is_member, got.is_member);
         if (got.cycle_total !== want.cycle_total)
            log_failure("cycle_total", want.cycle_total, got.cycle_total);
         if (got.open_length !== want.open_length)
            log_failure("open_length", want.open_length, got.open_length);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [1:0]             req_type;
   logic [ELEM_W-1:0]      req_element;
   logic                   rsp_valid;
   logic [ORDER_WIDTH-1:0] rsp_perm_order;
   logic                   rsp_order_overflow;
   logic                   rsp_is_member;
   logic [CLOSED_W-1:0]    rsp_cycle_total;
   logic [OPEN_W-1:0]      rsp_open_length;

   cycle_order_checker sb;
   int  request_count;
   bit  no_idle;
   int  idle_cycles;
   int  prime_lengths [7] = '{29, 31, 37, 41, 43, 47, 53};

   permutation_cycle_order_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_element(req_element),
      .rsp_valid(rsp_valid),
      .rsp_perm_order(rsp_perm_order),
      .rsp_order_overflow(rsp_order_overflow),
      .rsp_is_member(rsp_is_member),
      .rsp_cycle_total(rsp_cycle_total),
      .rsp_open_length(rsp_open_length)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      order_report_type got;
      if (!reset && rsp_valid) begin
         got.perm_order = rsp_perm_order;
         got.order_overflow = rsp_order_overflow;
         got.is_member = rsp_is_member;
         got.cycle_total = rsp_cycle_total;
         got.open_length = rsp_open_length;
         sb.check_report(got);
      end
   end

   // Any request or result taken resets the stall counter.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 120);
   endfunction

   function automatic logic [ELEM_W-1:0] any_element();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return ELEM_W'($urandom_range(0, ELEMENT_COUNT - 1));
   endfunction

   function automatic int pick_length(bit wide);
      int r;
      r = $urandom_range(0, 99);
      if (!wide) return (r < 70) ? $urandom_range(2, 8) : $urandom_range(9, 16);
      if (r < 90) return $urandom_range(2, 48);
      return $urandom_range(60, 200);
   endfunction

   // Start stays high on return; whoever waits next lowers it first.
   task automatic send_request(input logic [1:0] kind, input logic [ELEM_W-1:0] elem);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_element <= elem;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_request(kind, elem);
      if (kind != REQ_UNKNOWN) request_count++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
   endtask

   task automatic run_cycle(input int len);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(0, 9) == 0) send_request(pcord_pkg::REQ_QUERY, any_element());
         send_request(pcord_pkg::REQ_ADD, any_element());
      end
      send_request(pcord_pkg::REQ_CLOSE, any_element());
   endtask

   initial begin
      int roll;
      sb = new();
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_type = pcord_pkg::REQ_ADD;
      req_element = '0;
      request_count = 0;
      no_idle = 1'b0;
      idle_cycles = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed: empty map, empty close, fixed point, repeats, unknown code.
      send_request(pcord_pkg::REQ_QUERY, 10'd0);
      send_request(pcord_pkg::REQ_QUERY, 10'd1023);
      send_request(pcord_pkg::REQ_CLOSE, 10'd0);
      send_request(pcord_pkg::REQ_ADD, 10'd0);
      send_request(pcord_pkg::REQ_ADD, 10'd1023);
      send_request(pcord_pkg::REQ_CLOSE, 10'd1023);
      send_request(pcord_pkg::REQ_ADD, 10'd5);
      send_request(pcord_pkg::REQ_CLOSE, 10'd5);
      send_request(pcord_pkg::REQ_QUERY, 10'd5);
      send_request(pcord_pkg::REQ_ADD, 10'd0);
      send_request(pcord_pkg::REQ_ADD, 10'd0);
      send_request(pcord_pkg::REQ_ADD, 10'd1023);
      send_request(pcord_pkg::REQ_CLOSE, 10'd0);
      send_request(REQ_UNKNOWN, 10'd1023);
      send_request(REQ_UNKNOWN, 10'd0);
      send_request(pcord_pkg::REQ_QUERY, 10'd1023);
      send_request(pcord_pkg::REQ_QUERY, 10'd512);
      send_request(pcord_pkg::REQ_ADD, 10'd682);
      send_request(pcord_pkg::REQ_ADD, 10'd341);
      send_request(pcord_pkg::REQ_CLOSE, 10'd682);
      send_request(pcord_pkg::REQ_QUERY, 10'd682);
      send_request(pcord_pkg::REQ_QUERY, 10'd341);
      drain_results();

      // Mostly whole cycles with random content; lengths widen late in the run
      // so that the order usually saturates only near the end.
      request_count = 0;
      while (request_count < RANDOM_REQUESTS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            run_cycle(pick_length(request_count > WIDE_LENGTHS_FROM));
         end else if (roll < 85) begin
            repeat ($urandom_range(1, 3)) send_request(pcord_pkg::REQ_QUERY, any_element());
         end else if (roll < 90) begin
            send_request(REQ_UNKNOWN, any_element());
         end else if (roll < 94) begin
            send_request(pcord_pkg::REQ_CLOSE, any_element());
         end else if (roll < 97) begin
            run_cycle(1);
         end else begin
            drain_results();
         end
      end
      no_idle = 1'b0;
      drain_results();

      // Coprime lengths whose product exceeds the order width.
      foreach (prime_lengths[i]) run_cycle(prime_lengths[i]);
      send_request(pcord_pkg::REQ_QUERY, any_element());
      send_request(pcord_pkg::REQ_CLOSE, 10'd0);
      send_request(REQ_UNKNOWN, 10'd512);

      drain_results();
      repeat (150) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

@@ permutation_cycle_order_core.f @@
hw/rtl/pcord_pkg.sv
hw/rtl/permutation_cycle_order_core.sv
dv/permutation_cycle_order_core_test.sv
